>>> hdl/i2rpb_pkg.sv
// Shared types, codes and constants for the register-write PWM bridge.
package i2rpb_pkg;

    localparam int unsigned CLK_HZ_W    = 27;
    localparam int unsigned PERIOD_W    = 16;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned PROD_W      = PERIOD_W + WORD_W;
    localparam int unsigned DIV_CNT_W   = $clog2(CLK_HZ_W);
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 24;
    localparam int unsigned M_TUSER_W   = 3;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam logic [CLK_HZ_W-1:0] CLK_HZ_RESET = CLK_HZ_W'(48000000);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_CLK_HZ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b1;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_STOP = 1'b1;

    typedef enum logic [1:0] {
        ACT_PRESCALER = 2'd0,
        ACT_COMPARE   = 2'd1,
        ACT_DIRECTION = 2'd2,
        ACT_REJECT    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        RK_PRESCALER,
        RK_COMPARE,
        RK_DIRECTION,
        RK_UNKNOWN
    } reg_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic gather;
        logic mult;
        logic div_init;
        logic div_step;
        logic load_out;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic      complete;
        reg_kind_t kind;
        logic      prod_zero;
        logic      div_last;
        logic      out_free;
    } status_t;

    function automatic reg_kind_t reg_kind(input logic [7:0] id);
        reg_kind_t k;
        case (id)
            8'd1, 8'd2:                      k = RK_PRESCALER;
            8'd4, 8'd5, 8'd6, 8'd7,
            8'd10, 8'd11:                    k = RK_COMPARE;
            8'd12:                           k = RK_DIRECTION;
            default:                         k = RK_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

>>> hdl/i2rpb_ctrl.sv
// Sequencer for gathering, prescaler division and result hand-off.
module i2rpb_ctrl
    import i2rpb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    s_tuser,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == REQ_BYTE) begin
                        cmd.gather = 1'b1;
                    end else if (status.complete) begin
                        case (status.kind)
                            RK_PRESCALER: begin
                                cmd.mult   = 1'b1;
                                state_next = ST_MULT;
                            end
                            RK_COMPARE, RK_DIRECTION: begin
                                state_next = ST_OUT;
                            end
                            default: begin
                                cmd.clear = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_MULT: begin
                if (status.prod_zero) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/i2rpb_dp.sv
// Gather registers, configuration, multiplier, restoring divider and output word.
module i2rpb_dp
    import i2rpb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CLK_HZ_W-1:0]   cfg_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser,
    input  cmd_t                  cmd,
    output status_t               status
);

    logic [CLK_HZ_W-1:0]  clk_hz_reg;
    logic [PERIOD_W-1:0]  period_reg;

    logic                 have_reg;
    logic [7:0]           reg_id_reg;
    logic [1:0]           cnt_reg;
    logic [WORD_W-1:0]    word_reg;

    logic [PROD_W-1:0]    prod_reg;
    logic [CLK_HZ_W-1:0]  quo_reg, quo_next;
    logic [CLK_HZ_W-1:0]  rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    logic [CLK_HZ_W:0]    rem_sh;
    logic                 ge;
    logic [CLK_HZ_W-1:0]  diff;

    action_t              act;
    logic                 tsel;
    logic [2:0]           chan;
    logic [WORD_W-1:0]    val;
    logic                 fwd, bwd;
    reg_kind_t            kind;

    assign kind = reg_kind(reg_id_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg <= CLK_HZ_RESET;
            period_reg <= PERIOD_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_CLK_HZ) begin
                clk_hz_reg <= cfg_data;
            end else if (cfg_index == CFG_PERIOD) begin
                period_reg <= cfg_data[PERIOD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg   <= 1'b0;
            reg_id_reg <= '0;
            cnt_reg    <= '0;
            word_reg   <= '0;
        end else if (cmd.clear) begin
            have_reg   <= 1'b0;
            reg_id_reg <= '0;
            cnt_reg    <= '0;
            word_reg   <= '0;
        end else if (cmd.gather) begin
            if (!have_reg) begin
                reg_id_reg <= s_tdata;
                have_reg   <= 1'b1;
            end else if (cnt_reg == 2'd0) begin
                word_reg[7:0] <= s_tdata;
                cnt_reg       <= 2'd1;
            end else if (cnt_reg == 2'd1) begin
                word_reg[15:8] <= s_tdata;
                cnt_reg        <= 2'd2;
            end
        end
    end

    assign rem_sh = {rem_reg, quo_reg[CLK_HZ_W-1]};
    assign ge     = ({{(PROD_W-CLK_HZ_W-1){1'b0}}, rem_sh} >= prod_reg);
    assign diff   = rem_sh[CLK_HZ_W-1:0] - prod_reg[CLK_HZ_W-1:0];

    always_comb begin
        rem_next = ge ? diff : rem_sh[CLK_HZ_W-1:0];
        quo_next = {quo_reg[CLK_HZ_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (cmd.mult) begin
            prod_reg <= PROD_W'(period_reg) * PROD_W'(word_reg);
        end
        if (cmd.div_init) begin
            quo_reg     <= clk_hz_reg;
            rem_reg     <= '0;
            div_cnt_reg <= DIV_CNT_W'(CLK_HZ_W - 1);
        end else if (cmd.div_step) begin
            quo_reg     <= quo_next;
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_comb begin
        act  = ACT_REJECT;
        tsel = 1'b0;
        chan = '0;
        val  = '0;
        fwd  = 1'b0;
        bwd  = 1'b0;
        case (kind)
            RK_PRESCALER: begin
                tsel = (reg_id_reg == 8'd2);
                if (prod_reg == '0) begin
                    act = ACT_REJECT;
                end else begin
                    act = ACT_PRESCALER;
                    if (quo_reg != '0) begin
                        val = quo_reg[WORD_W-1:0] - WORD_W'(1);
                    end
                end
            end
            RK_COMPARE: begin
                act = ACT_COMPARE;
                if (reg_id_reg <= 8'd7) begin
                    chan = reg_id_reg[2:0] - 3'd3;
                end else begin
                    tsel = 1'b1;
                    chan = reg_id_reg[2:0] - 3'd7;
                end
                val = (word_reg > period_reg) ? period_reg : word_reg;
            end
            RK_DIRECTION: begin
                act = ACT_DIRECTION;
                fwd = word_reg[0];
                bwd = word_reg[8];
            end
            default: begin
                act = ACT_REJECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg <= {3'b000, bwd, fwd, val, chan};
            m_user_reg <= {tsel, act};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign status.complete  = have_reg && (cnt_reg == 2'd2);
    assign status.kind      = kind;
    assign status.prod_zero = (prod_reg == '0);
    assign status.div_last  = (div_cnt_reg == '0);
    assign status.out_free  = !m_valid_reg || m_tready;

endmodule

>>> hdl/i2c_register_write_pwm_bridge.sv
// Top level of the bus register-write to PWM timer bridge.
// A data-byte word, and a stop that decodes nothing, are handled without leaving the idle state.
// A compare or direction stop passes through ST_OUT, which loads the registered result word once the output is free.
// A prescaler stop runs one multiply, then 27 restoring divider steps, one per
// cycle, then the output load; a zero divisor skips the divider and goes straight to the output load.
// aresetn is synchronous: configuration returns to 48 MHz and period 1000.
module i2c_register_write_pwm_bridge
    import i2rpb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
    input  logic                 s_tuser,   // [0] req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] channel, [18:3] reg_value,
                                            // [19] dir_forward, [20] dir_backward
    output logic [M_TUSER_W-1:0] m_tuser,   // [1:0] action, [2] timer_sel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CLK_HZ_W-1:0]  cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    i2rpb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    i2rpb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> hdl/i2rpb_checker.sv
// Port-level checks on the bridge, bound to the top level.
module i2rpb_checker
    import i2rpb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("stalled result word dropped");

    a_byte_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_BYTE) |=> !$rose(m_tvalid))
        else $error("data byte word produced a result");

    a_reject_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == ACT_REJECT) |-> (m_tdata == '0))
        else $error("rejected frequency carries payload");

    a_direction_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == ACT_DIRECTION)
            |-> (m_tuser[2] == 1'b0) && (m_tdata[18:0] == '0))
        else $error("direction word carries timer fields");

endmodule

bind i2c_register_write_pwm_bridge i2rpb_checker u_i2rpb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/pwm_write_checker.sv
// Checker for the register-write PWM bridge: tracks bus writes, predicts timer updates, compares.
module pwm_write_checker
    import i2rpb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CLK_HZ_W-1:0]  cfg_data,
    output int                   errors,
    output int                   pending
);

    localparam logic [7:0] REG_SERVO_PSC = 8'd1;
    localparam logic [7:0] REG_MOTOR_PSC = 8'd2;
    localparam logic [7:0] REG_SERVO_CH1 = 8'd4;
    localparam logic [7:0] REG_SERVO_CH2 = 8'd5;
    localparam logic [7:0] REG_SERVO_CH3 = 8'd6;
    localparam logic [7:0] REG_SERVO_CH4 = 8'd7;
    localparam logic [7:0] REG_MOTOR_CH3 = 8'd10;
    localparam logic [7:0] REG_MOTOR_CH4 = 8'd11;
    localparam logic [7:0] REG_DIRECTION = 8'd12;

    typedef struct packed {
        action_t       action;
        logic          timer_sel;
        logic [2:0]    channel;
        logic [15:0]   value;
        logic          fwd;
        logic          bwd;
    } timer_update_t;

    logic                have_reg;
    logic [7:0]          reg_id;
    logic [1:0]          data_cnt;
    logic [15:0]         data_word;
    logic [CLK_HZ_W-1:0] clk_hz;
    logic [PERIOD_W-1:0] period;
    timer_update_t       timer_updates[$];
    int                  fail_count;

    function automatic bit decode_write(output timer_update_t upd);
        logic [31:0] divisor;
        logic [31:0] quot;
        bit          hit;
        upd = '0;
        hit = 1'b1;
        case (reg_id)
            REG_SERVO_PSC, REG_MOTOR_PSC: begin
                upd.timer_sel = (reg_id == REG_MOTOR_PSC);
                divisor = 32'(period) * 32'(data_word);
                if (divisor == 32'd0) begin
                    upd.action = ACT_REJECT;
                end else begin
                    quot = 32'(clk_hz) / divisor;
                    if (quot == 32'd0) begin
                        quot = 32'd1;
                    end
                    upd.action = ACT_PRESCALER;
                    upd.value = quot[15:0] - 16'd1;
                end
            end
            REG_SERVO_CH1, REG_SERVO_CH2, REG_SERVO_CH3, REG_SERVO_CH4: begin
                upd.action = ACT_COMPARE;
                upd.channel = 3'(reg_id - REG_SERVO_CH1 + 8'd1);
                upd.value = (data_word > period) ? period : data_word;
            end
            REG_MOTOR_CH3, REG_MOTOR_CH4: begin
                upd.action = ACT_COMPARE;
                upd.timer_sel = 1'b1;
                upd.channel = 3'(reg_id - REG_MOTOR_CH3 + 8'd3);
                upd.value = (data_word > period) ? period : data_word;
            end
            REG_DIRECTION: begin
                upd.action = ACT_DIRECTION;
                upd.fwd = data_word[0];
                upd.bwd = data_word[8];
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        return hit;
    endfunction

    always @(posedge aclk) begin : watch
        timer_update_t upd;
        timer_update_t got;
        timer_update_t want;
        if (!aresetn) begin
            clk_hz = CLK_HZ_RESET;
            period = PERIOD_RESET;
            have_reg = 1'b0;
            reg_id = '0;
            data_cnt = '0;
            data_word = '0;
            timer_updates.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_CLK_HZ) begin
                    clk_hz = cfg_data;
                end else begin
                    period = cfg_data[PERIOD_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_BYTE) begin
                    if (!have_reg) begin
                        reg_id = s_tdata;
                        have_reg = 1'b1;
                    end else if (data_cnt == 2'd0) begin
                        data_word[7:0] = s_tdata;
                        data_cnt = 2'd1;
                    end else if (data_cnt == 2'd1) begin
                        data_word[15:8] = s_tdata;
                        data_cnt = 2'd2;
                    end
                end else if (have_reg && data_cnt == 2'd2) begin
                    if (decode_write(upd)) begin
                        timer_updates.push_back(upd);
                    end
                    have_reg = 1'b0;
                    reg_id = '0;
                    data_cnt = '0;
                    data_word = '0;
                end
            end
            if (m_tvalid && m_tready) begin
                got.action = action_t'(m_tuser[1:0]);
                got.timer_sel = m_tuser[2];
                got.channel = m_tdata[2:0];
                got.value = m_tdata[18:3];
                got.fwd = m_tdata[19];
                got.bwd = m_tdata[20];
                if (timer_updates.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected word: action %0d sel %0b ch %0d value %0d",
                                 got.action, got.timer_sel, got.channel, got.value);
                    end
                    fail_count++;
                end else begin
                    want = timer_updates.pop_front();
                    if (got.action !== want.action || got.timer_sel !== want.timer_sel ||
                        got.channel !== want.channel || got.value !== want.value ||
                        got.fwd !== want.fwd || got.bwd !== want.bwd ||
                        m_tdata[M_TDATA_W-1:21] !== '0) begin
                        if (fail_count < 10) begin
                            $display("mismatch: expected action %0d sel %0b ch %0d value %0d fwd %0b bwd %0b",
                                     want.action, want.timer_sel, want.channel, want.value,
                                     want.fwd, want.bwd);
                            $display("          got      action %0d sel %0b ch %0d value %0d fwd %0b bwd %0b pad %0h",
                                     got.action, got.timer_sel, got.channel, got.value,
                                     got.fwd, got.bwd, m_tdata[M_TDATA_W-1:21]);
                        end
                        fail_count++;
                    end
                end
            end
        end
        errors <= fail_count;
        pending <= timer_updates.size();
    end

endmodule

>>> tb/i2c_register_write_pwm_bridge_test.sv
// Testbench top for the register-write PWM bridge: clock, reset, stimulus and verdict.
module i2c_register_write_pwm_bridge_test;
    import i2rpb_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASE_WORDS     = 105;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 250;

    localparam logic [7:0] REG_SERVO_PSC = 8'd1;
    localparam logic [7:0] REG_MOTOR_PSC = 8'd2;
    localparam logic [7:0] REG_SERVO_CH1 = 8'd4;
    localparam logic [7:0] REG_SERVO_CH2 = 8'd5;
    localparam logic [7:0] REG_SERVO_CH3 = 8'd6;
    localparam logic [7:0] REG_SERVO_CH4 = 8'd7;
    localparam logic [7:0] REG_MOTOR_CH3 = 8'd10;
    localparam logic [7:0] REG_MOTOR_CH4 = 8'd11;
    localparam logic [7:0] REG_DIRECTION = 8'd12;
    localparam logic [7:0] REG_UNKNOWN   = 8'hFF;

    localparam logic [7:0] KNOWN_REGS [9] = '{
        REG_SERVO_PSC, REG_MOTOR_PSC, REG_SERVO_CH1, REG_SERVO_CH2, REG_SERVO_CH3,
        REG_SERVO_CH4, REG_MOTOR_CH3, REG_MOTOR_CH4, REG_DIRECTION
    };

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CLK_HZ_W-1:0]  cfg_data  = '0;

    int                   errors;
    int                   pending;
    int                   words_sent  = 0;
    int                   burst_left  = 0;
    int                   idle_cycles = 0;
    logic [PERIOD_W-1:0]  cur_period  = PERIOD_RESET;

    i2c_register_write_pwm_bridge u_top (.*);

    pwm_write_checker u_check (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic kind, input logic [7:0] b);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        words_sent++;
    endtask

    task automatic write_reg(input logic [7:0] id, input logic [15:0] value, input int extra);
        send_word(REQ_BYTE, id);
        send_word(REQ_BYTE, value[7:0]);
        send_word(REQ_BYTE, value[15:8]);
        repeat (extra) send_word(REQ_BYTE, 8'($urandom));
        send_word(REQ_STOP, 8'($urandom));
    endtask

    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h0000;
            1:       v = 16'hFFFF;
            2:       v = 16'h0001;
            3:       v = 16'(cur_period + $urandom_range(0, 2) - 1);
            4:       v = 16'($urandom_range(1, 64));
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic random_traffic(input int n_words);
        int          stop_at;
        int          pick;
        logic [7:0]  id;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            id = ($urandom_range(0, 6) == 0) ? 8'($urandom) : KNOWN_REGS[$urandom_range(0, 8)];
            if (pick < 72) begin
                write_reg(id, pick_value(),
                          ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
            end else if (pick < 87) begin
                send_word(REQ_BYTE, id);
                repeat ($urandom_range(0, 1)) send_word(REQ_BYTE, 8'($urandom));
                send_word(REQ_STOP, 8'($urandom));
            end else begin
                send_word(1'($urandom_range(0, 1)), 8'($urandom));
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CLK_HZ_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CLK_HZ_W-1:0] hz, input logic [PERIOD_W-1:0] per);
        cfg_write(CFG_CLK_HZ, hz);
        cfg_write(CFG_PERIOD, CLK_HZ_W'(per));
        cfg_valid <= 1'b0;
        cur_period = per;
    endtask

    // receiver: stall stretches of varying density, one long hold-off to back the block up
    initial begin : receiver
        int pct;
        bit long_hold_done;
        long_hold_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && words_sent >= HOLD_OFF_AFTER) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                case ($urandom_range(0, 3))
                    0:       pct = 0;
                    1:       pct = 30;
                    2:       pct = 70;
                    default: pct = 95;
                endcase
                repeat ($urandom_range(20, 200)) begin
                    m_tready <= ($urandom_range(0, 99) >= pct);
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        int phase;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(REQ_STOP, 8'h00);
        write_reg(REG_SERVO_PSC, 16'd50, 0);
        write_reg(REG_MOTOR_PSC, 16'd0, 0);
        write_reg(REG_SERVO_CH1, 16'hFFFF, 0);
        write_reg(REG_MOTOR_CH4, 16'h0000, 0);
        write_reg(REG_DIRECTION, 16'h0101, 0);
        // early stop: hold partial write, finish it in the next transaction
        send_word(REQ_BYTE, REG_SERVO_CH2);
        send_word(REQ_BYTE, 8'hE8);
        send_word(REQ_STOP, 8'hFF);
        send_word(REQ_BYTE, 8'h03);
        send_word(REQ_STOP, 8'h00);
        write_reg(REG_SERVO_CH3, 16'h0123, 2);
        write_reg(REG_UNKNOWN, 16'hABCD, 0);
        write_reg(REG_MOTOR_CH3, 16'h03E7, 0);
        random_traffic(PHASE_WORDS);
        drain();

        for (phase = 1; phase <= 6; phase++) begin
            case (phase)
                1:       set_config(CLK_HZ_W'(100_000_000), 16'd1);
                2:       set_config('0, 16'hFFFF);
                3:       set_config(CLK_HZ_W'(1), 16'd0);
                4:       set_config('1, 16'($urandom_range(1, 65535)));
                5:       set_config(CLK_HZ_W'($urandom_range(1, 100_000_000)),
                                    16'($urandom_range(1, 300)));
                default: set_config(CLK_HZ_W'(48_000_000), 16'd20000);
            endcase
            write_reg(REG_SERVO_PSC, 16'd1, 0);
            write_reg(REG_MOTOR_PSC, 16'hFFFF, 0);
            write_reg(REG_SERVO_CH4, 16'hFFFF, 0);
            random_traffic(PHASE_WORDS);
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
